// ===== hdl/lfsr_ranged_random_top_macros.svh =====
// Assertion macros shared by the generator modules.
// Needs nothing else; define ASSERT_OFF to compile them away.
`ifndef LFSR_RANGED_RANDOM_TOP_MACROS_SVH
`define LFSR_RANGED_RANDOM_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define LRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/lrr_pkg.sv =====
// Types and constants shared by the ranged random generator modules.
// Depends on nothing.
package lrr_pkg;

    localparam int DATA_W   = 64;
    localparam int LFSR_W   = 128;
    localparam int MAX_BITS = 64;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 8;

    typedef enum logic [OP_W-1:0] {
        CMD_RESEED = 2'd0,
        CMD_BITS   = 2'd1,
        CMD_RANGE  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic capture;
        logic seed_load;
        logic warm_step;
        logic len_init;
        logic len_step;
        logic draw_init;
        logic draw_step;
        logic draw_end;
        logic mod_step;
        logic add_step;
        logic res_zero;
        logic res_err;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd op;
        logic bits_ok;
        logic range_ok;
        logic cnt_zero;
        logic diff_zero;
    } t_dp_stat;

endpackage

// ===== hdl/lrr_datapath.sv =====
// Datapath of the ranged random generator: the 128-bit shift register,
// step counter, bit length scan, range reduction and result registers.
// Depends on lrr_pkg and the assertion macro header.
`include "lfsr_ranged_random_top_macros.svh"

module lrr_datapath #(
    parameter int WARMUP_STEPS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrr_pkg::t_dp_cmd              i_cmd,
    output lrr_pkg::t_dp_stat             o_stat,
    input  logic [lrr_pkg::OP_W-1:0]      i_op,
    input  logic [lrr_pkg::DATA_W-1:0]    i_seed_low,
    input  logic [lrr_pkg::DATA_W-1:0]    i_seed_high,
    input  logic [lrr_pkg::COUNT_W-1:0]   i_bit_count,
    input  logic                          i_force_top_bit,
    input  logic [lrr_pkg::DATA_W-1:0]    i_range_low,
    input  logic [lrr_pkg::DATA_W-1:0]    i_range_high,
    output logic [lrr_pkg::DATA_W-1:0]    o_value,
    output logic                          o_status
);

    localparam int CNT_W = $clog2(WARMUP_STEPS + lrr_pkg::MAX_BITS + 1);

    function automatic logic [lrr_pkg::LFSR_W-1:0] lfsr_next(
        input logic [lrr_pkg::LFSR_W-1:0] s
    );
        logic fb;
        fb = s[0] ^ s[1] ^ s[2] ^ s[7];
        return {fb, s[lrr_pkg::LFSR_W-1:1]};
    endfunction

    logic [lrr_pkg::OP_W-1:0]    r_op;
    logic [lrr_pkg::DATA_W-1:0]  r_seed_low, r_seed_high;
    logic [lrr_pkg::COUNT_W-1:0] r_bit_count;
    logic                        r_force;
    logic [lrr_pkg::DATA_W-1:0]  r_lo, r_hi;

    logic [lrr_pkg::LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [lrr_pkg::DATA_W-1:0]  r_acc, n_acc;
    logic [lrr_pkg::DATA_W-1:0]  r_diff, n_diff;
    logic [lrr_pkg::DATA_W-1:0]  r_span, n_span;
    logic [lrr_pkg::DATA_W-1:0]  r_value, n_value;
    logic                        r_status, n_status;

    logic [lrr_pkg::LFSR_W-1:0]  stepped;
    logic [lrr_pkg::DATA_W-1:0]  draw_final;

    assign stepped    = lfsr_next(r_lfsr);
    assign draw_final = r_acc | {{(lrr_pkg::DATA_W-1){1'b0}}, r_lfsr[0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op        <= i_op;
            r_seed_low  <= i_seed_low;
            r_seed_high <= i_seed_high;
            r_bit_count <= i_bit_count;
            r_force     <= i_force_top_bit;
            r_lo        <= i_range_low;
            r_hi        <= i_range_high;
        end
    end

    always_comb begin
        n_lfsr = r_lfsr;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_diff = r_diff;
        n_span = r_span;
        if (i_cmd.seed_load) begin
            n_lfsr = {r_seed_high, r_seed_low};
            n_cnt  = CNT_W'(WARMUP_STEPS);
        end
        if (i_cmd.warm_step) begin
            n_lfsr = stepped;
            n_cnt  = r_cnt - CNT_W'(1);
        end
        if (i_cmd.len_init) begin
            n_diff = r_hi - r_lo;
            n_span = r_hi - r_lo + lrr_pkg::DATA_W'(1);
            n_cnt  = '0;
        end
        if (i_cmd.len_step) begin
            n_diff = r_diff >> 1;
            n_cnt  = r_cnt + CNT_W'(1);
        end
        if (i_cmd.draw_init) begin
            n_acc = '0;
            if (lrr_pkg::t_cmd'(r_op) == lrr_pkg::CMD_RANGE) begin
                n_cnt = (r_cnt == '0) ? '0 : r_cnt - CNT_W'(1);
            end else begin
                n_cnt = CNT_W'(r_bit_count - lrr_pkg::COUNT_W'(1));
            end
        end
        if (i_cmd.draw_step) begin
            n_lfsr = stepped;
            n_acc  = (r_acc | {{(lrr_pkg::DATA_W-1){1'b0}}, stepped[0]}) << 1;
            n_cnt  = r_cnt - CNT_W'(1);
        end
        if (i_cmd.draw_end) begin
            n_acc = draw_final;
        end
        if (i_cmd.mod_step) begin
            if (r_span != '0 && r_acc >= r_span) begin
                n_acc = r_acc - r_span;
            end
        end
    end

    always_comb begin
        n_value  = r_value;
        n_status = r_status;
        if (i_cmd.res_zero) begin
            n_value  = '0;
            n_status = i_cmd.res_err;
        end
        if (i_cmd.draw_end && lrr_pkg::t_cmd'(r_op) == lrr_pkg::CMD_BITS) begin
            n_value = draw_final | {r_force, {(lrr_pkg::DATA_W-1){1'b0}}};
        end
        if (i_cmd.add_step) begin
            n_value = (r_span == '0) ? r_acc : r_lo + r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr   <= '0;
            r_value  <= '0;
            r_status <= 1'b0;
        end else begin
            r_lfsr   <= n_lfsr;
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_diff <= n_diff;
        r_span <= n_span;
    end

    assign o_stat.op        = lrr_pkg::t_cmd'(r_op);
    assign o_stat.bits_ok   = (r_bit_count != '0) &&
                              (r_bit_count <= lrr_pkg::COUNT_W'(lrr_pkg::MAX_BITS));
    assign o_stat.range_ok  = (r_lo <= r_hi);
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.diff_zero = (r_diff == '0);

    assign o_value  = r_value;
    assign o_status = r_status;

    `LRR_ASSERT_IMP(a_err_value_zero, i_clk, i_rst_n, r_status, r_value == '0)
    `LRR_ASSERT_NEXT(a_err_keeps_state, i_clk, i_rst_n, i_cmd.res_zero && i_cmd.res_err, $stable(r_lfsr))
    `LRR_ASSERT_NEXT(a_len_shift, i_clk, i_rst_n, i_cmd.len_step, r_diff == ($past(r_diff) >> 1))

endmodule

// ===== hdl/lrr_ctrl.sv =====
// Controller of the ranged random generator: sequences reseed, bit draw
// and ranged draw requests over the datapath. Depends on lrr_pkg and the
// assertion macro header.
`include "lfsr_ranged_random_top_macros.svh"

module lrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_strobe,
    input  lrr_pkg::t_dp_stat i_stat,
    output lrr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_WARM  = 8'b0000_0100,
        S_LEN   = 8'b0000_1000,
        S_DRAW  = 8'b0001_0000,
        S_MOD   = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.res_zero = 1'b1;
                unique case (i_stat.op)
                    lrr_pkg::CMD_RESEED: begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_WARM;
                    end
                    lrr_pkg::CMD_BITS: begin
                        if (i_stat.bits_ok) begin
                            o_cmd.draw_init = 1'b1;
                            n_state         = S_DRAW;
                        end else begin
                            o_cmd.res_err = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    lrr_pkg::CMD_RANGE: begin
                        if (i_stat.range_ok) begin
                            o_cmd.len_init = 1'b1;
                            n_state        = S_LEN;
                        end else begin
                            o_cmd.res_err = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.res_err = 1'b1;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_WARM: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.warm_step = 1'b1;
                end
            end
            S_LEN: begin
                if (i_stat.diff_zero) begin
                    o_cmd.draw_init = 1'b1;
                    n_state         = S_DRAW;
                end else begin
                    o_cmd.len_step = 1'b1;
                end
            end
            S_DRAW: begin
                if (i_stat.cnt_zero) begin
                    o_cmd.draw_end = 1'b1;
                    n_state = (i_stat.op == lrr_pkg::CMD_RANGE) ? S_MOD : S_DONE;
                end else begin
                    o_cmd.draw_step = 1'b1;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_state        = S_ADD;
            end
            S_ADD: begin
                o_cmd.add_step = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

    `LRR_ASSERT_NEXT(a_start_to_check, i_clk, i_rst_n, i_start && !o_busy, r_state == S_CHECK)
    `LRR_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe && !o_busy)
    `LRR_ASSERT_NEXT(a_draw_holds, i_clk, i_rst_n, r_state == S_DRAW && !i_stat.cnt_zero, r_state == S_DRAW)

endmodule

// ===== hdl/lfsr_ranged_random_top.sv =====
// Top level of the 128-bit shift register random generator with ranged draw.
// Depends on lrr_pkg, lrr_ctrl and lrr_datapath.
//
// Channel   Direction  Handshake              Payload
// request   in         start high, busy low   i_cmd, i_seed_*, i_bit_count,
//                                             i_force_top_bit, i_range_*
// result    out        o_strobe, one cycle    o_value, o_status
//
// Request times grow with WARMUP_STEPS, the bit count and the bit length of high
// minus low, since the shift register advances a single step at a time and the
// length scan is bit-serial. Reset is synchronous and clears the generator state to zero.
// The result cannot be held off, and busy stays high until its strobe cycle ends.
module lfsr_ranged_random_top #(
    parameter int WARMUP_STEPS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lrr_pkg::OP_W-1:0]      i_cmd,
    input  logic [lrr_pkg::DATA_W-1:0]    i_seed_low,
    input  logic [lrr_pkg::DATA_W-1:0]    i_seed_high,
    input  logic [lrr_pkg::COUNT_W-1:0]   i_bit_count,
    input  logic                          i_force_top_bit,
    input  logic [lrr_pkg::DATA_W-1:0]    i_range_low,
    input  logic [lrr_pkg::DATA_W-1:0]    i_range_high,
    output logic                          o_strobe,
    output logic [lrr_pkg::DATA_W-1:0]    o_value,
    output logic                          o_status
);

    lrr_pkg::t_dp_cmd  dp_cmd;
    lrr_pkg::t_dp_stat dp_stat;

    lrr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd)
    );

    lrr_datapath #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_op            (i_cmd),
        .i_seed_low      (i_seed_low),
        .i_seed_high     (i_seed_high),
        .i_bit_count     (i_bit_count),
        .i_force_top_bit (i_force_top_bit),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .o_value         (o_value),
        .o_status        (o_status)
    );

endmodule

// ===== tb/lfsr_ranged_random_top_test.sv =====
// Self-checking testbench for lfsr_ranged_random_top: drives reseed, bit draw, ranged draw
// and unused-opcode requests and compares every result with an internal generator copy.
// Depends on lrr_pkg and the lfsr_ranged_random_top RTL.
module lfsr_ranged_random_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lrr_pkg::OP_W-1:0]    CMD_UNUSED      = 2'd3;
    localparam int                          WARMUP_STEPS    = 128;
    localparam int                          RANDOM_REQUESTS = 1030;
    localparam int                          DRAIN_CYCLES    = 2 * lrr_pkg::MAX_BITS + 16;
    localparam int                          CYCLE_LIMIT     = 1_000_000;
    localparam int                          MAX_REPORTS     = 10;
    localparam logic [lrr_pkg::DATA_W-1:0]  ALL_ONES        = '1;
    localparam logic [lrr_pkg::COUNT_W-1:0] FULL_COUNT      =
        lrr_pkg::COUNT_W'(lrr_pkg::MAX_BITS);

    typedef struct packed {
        logic [lrr_pkg::DATA_W-1:0] value;
        logic                       status;
    } t_draw;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [lrr_pkg::OP_W-1:0]      i_cmd;
    logic [lrr_pkg::DATA_W-1:0]    i_seed_low;
    logic [lrr_pkg::DATA_W-1:0]    i_seed_high;
    logic [lrr_pkg::COUNT_W-1:0]   i_bit_count;
    logic                          i_force_top_bit;
    logic [lrr_pkg::DATA_W-1:0]    i_range_low;
    logic [lrr_pkg::DATA_W-1:0]    i_range_high;
    logic                          o_strobe;
    logic [lrr_pkg::DATA_W-1:0]    o_value;
    logic                          o_status;

    logic [lrr_pkg::LFSR_W-1:0]    shadow_lfsr = '0;
    t_draw                         expected_draws[$];
    int                            error_count = 0;
    int                            cycle_count = 0;
    bit                            idle_on = 1'b1;

    lfsr_ranged_random_top #(
        .WARMUP_STEPS(WARMUP_STEPS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_seed_low     (i_seed_low),
        .i_seed_high    (i_seed_high),
        .i_bit_count    (i_bit_count),
        .i_force_top_bit(i_force_top_bit),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_strobe       (o_strobe),
        .o_value        (o_value),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [lrr_pkg::DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        if (roll < 97) return $urandom_range(5, 20);
        return $urandom_range(30, 150);
    endfunction

    function void advance_lfsr();
        logic fb;
        fb = shadow_lfsr[0] ^ shadow_lfsr[1] ^ shadow_lfsr[2] ^ shadow_lfsr[7];
        shadow_lfsr = {fb, shadow_lfsr[lrr_pkg::LFSR_W-1:1]};
    endfunction

    // The first bit read becomes the top bit of the n-bit draw; one shift precedes every bit but the last.
    function automatic logic [lrr_pkg::DATA_W-1:0] collect_bits(int n);
        logic [lrr_pkg::DATA_W-1:0] acc;
        acc = '0;
        for (int i = 1; i < n; i++) begin
            advance_lfsr();
            acc = (acc | lrr_pkg::DATA_W'(shadow_lfsr[0])) << 1;
        end
        return acc | lrr_pkg::DATA_W'(shadow_lfsr[0]);
    endfunction

    function automatic int bit_length(logic [lrr_pkg::DATA_W-1:0] v);
        int len;
        len = 0;
        while (v != 0) begin
            len++;
            v = v >> 1;
        end
        return len;
    endfunction

    function automatic t_draw predict_draw(logic [lrr_pkg::OP_W-1:0] cmd,
                                           logic [lrr_pkg::DATA_W-1:0] seed_low,
                                           logic [lrr_pkg::DATA_W-1:0] seed_high,
                                           logic [lrr_pkg::COUNT_W-1:0] bit_count,
                                           logic force_top,
                                           logic [lrr_pkg::DATA_W-1:0] lo,
                                           logic [lrr_pkg::DATA_W-1:0] hi);
        t_draw                      r;
        logic [lrr_pkg::DATA_W-1:0] diff;
        logic [lrr_pkg::DATA_W-1:0] span;
        logic [lrr_pkg::DATA_W-1:0] raw;
        int                         n;
        r = '0;
        case (cmd)
            lrr_pkg::CMD_RESEED: begin
                shadow_lfsr = {seed_high, seed_low};
                repeat (WARMUP_STEPS) advance_lfsr();
            end
            lrr_pkg::CMD_BITS: begin
                if (bit_count < 1 || bit_count > lrr_pkg::MAX_BITS) begin
                    r.status = 1'b1;
                end else begin
                    r.value = collect_bits(int'(bit_count));
                    if (force_top) r.value[lrr_pkg::DATA_W-1] = 1'b1;
                end
            end
            lrr_pkg::CMD_RANGE: begin
                if (lo > hi) begin
                    r.status = 1'b1;
                end else begin
                    diff = hi - lo;
                    span = diff + 1'b1;
                    n = bit_length(diff);
                    if (n == 0) n = 1;
                    raw = collect_bits(n);
                    r.value = (span == 0) ? raw : lo + raw % span;
                end
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(logic [lrr_pkg::OP_W-1:0] cmd,
                                logic [lrr_pkg::DATA_W-1:0] seed_low,
                                logic [lrr_pkg::DATA_W-1:0] seed_high,
                                logic [lrr_pkg::COUNT_W-1:0] bit_count,
                                logic force_top, logic [lrr_pkg::DATA_W-1:0] lo,
                                logic [lrr_pkg::DATA_W-1:0] hi);
        int gap;
        i_cmd           <= cmd;
        i_seed_low      <= seed_low;
        i_seed_high     <= seed_high;
        i_bit_count     <= bit_count;
        i_force_top_bit <= force_top;
        i_range_low     <= lo;
        i_range_high    <= hi;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_draws.push_back(predict_draw(cmd, seed_low, seed_high, bit_count,
                                              force_top, lo, hi));
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_reseed(logic [lrr_pkg::LFSR_W-1:0] seed);
        send_request(lrr_pkg::CMD_RESEED, seed[lrr_pkg::DATA_W-1:0],
                     seed[lrr_pkg::LFSR_W-1:lrr_pkg::DATA_W], lrr_pkg::COUNT_W'($urandom),
                     1'($urandom), rand64(), rand64());
    endtask

    task automatic send_bits(logic [lrr_pkg::COUNT_W-1:0] n, logic force_top);
        send_request(lrr_pkg::CMD_BITS, rand64(), rand64(), n, force_top, rand64(), rand64());
    endtask

    task automatic send_range(logic [lrr_pkg::DATA_W-1:0] lo, logic [lrr_pkg::DATA_W-1:0] hi);
        send_request(lrr_pkg::CMD_RANGE, rand64(), rand64(), lrr_pkg::COUNT_W'($urandom),
                     1'($urandom), lo, hi);
    endtask

    task automatic send_unused();
        send_request(CMD_UNUSED, rand64(), rand64(), lrr_pkg::COUNT_W'($urandom), 1'($urandom),
                     rand64(), rand64());
    endtask

    // Straight out of reset the register is all zeros, so every drawn bit is zero.
    task automatic test_zero_state();
        send_bits(FULL_COUNT, 1'b0);
        send_bits(1, 1'b1);
        send_range(5, 1000);
    endtask

    task automatic test_bit_draws();
        send_reseed('1);
        send_bits(1, 1'b0);
        send_bits(FULL_COUNT, 1'b0);
        send_bits(FULL_COUNT, 1'b1);
        send_bits(33, 1'b1);
        send_reseed({64'hfedc_ba98_7654_3210, 64'h0123_4567_89ab_cdef});
        send_bits(7, 1'b0);
    endtask

    // Rejected requests must leave the register untouched; the last draw shows it.
    task automatic test_bad_arguments();
        send_bits(0, 1'b1);
        send_bits(FULL_COUNT + 1'b1, 1'b0);
        send_bits(8'hff, 1'b1);
        send_range(ALL_ONES, 0);
        send_range(2, 1);
        send_unused();
        send_bits(FULL_COUNT, 1'b0);
    endtask

    task automatic test_range_edges();
        send_range(0, 0);
        send_range(ALL_ONES, ALL_ONES);
        send_range(0, ALL_ONES);
        send_range(1, ALL_ONES);
        send_range(ALL_ONES - 1, ALL_ONES);
        send_range(0, 64'h8000_0000_0000_0000);
    endtask

    task automatic test_random_mix();
        int                         roll;
        logic [lrr_pkg::DATA_W-1:0] lo;
        logic [lrr_pkg::DATA_W-1:0] hi;
        logic [lrr_pkg::DATA_W-1:0] diff;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_reseed(($urandom_range(0, 19) == 0) ? '0 : {rand64(), rand64()});
            end else if (roll < 48) begin
                send_bits(lrr_pkg::COUNT_W'($urandom_range(1, lrr_pkg::MAX_BITS)),
                          1'($urandom));
            end else if (roll < 88) begin
                diff = rand64() >> $urandom_range(0, lrr_pkg::DATA_W);
                lo = (diff == 0) ? rand64() : rand64() % (ALL_ONES - diff + 1'b1);
                send_range(lo, lo + diff);
            end else if (roll < 94) begin
                send_bits(($urandom_range(0, 3) == 0) ? '0 :
                          lrr_pkg::COUNT_W'($urandom_range(lrr_pkg::MAX_BITS + 1, 255)),
                          1'($urandom));
            end else if (roll < 98) begin
                hi = rand64();
                if (hi == ALL_ONES) hi = hi - 1'b1;
                lo = hi + 1'b1 + rand64() % (ALL_ONES - hi);
                send_range(lo, hi);
            end else begin
                send_unused();
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_draw want;
        if (i_rst_n && o_strobe) begin
            if (expected_draws.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("Unexpected result: value %h status %0d", o_value, o_status);
            end else begin
                want = expected_draws.pop_front();
                if (o_value !== want.value || o_status !== want.status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Mismatch: value %h status %0d, expected value %h status %0d",
                                 o_value, o_status, want.value, want.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cmd           <= lrr_pkg::CMD_RESEED;
        i_seed_low      <= '0;
        i_seed_high     <= '0;
        i_bit_count     <= '0;
        i_force_top_bit <= 1'b0;
        i_range_low     <= '0;
        i_range_high    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_state();
        test_bit_draws();
        test_bad_arguments();
        test_range_edges();
        test_random_mix();

        start <= 1'b0;
        while (expected_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lrr_pkg.sv
hdl/lrr_datapath.sv
hdl/lrr_ctrl.sv
hdl/lfsr_ranged_random_top.sv
tb/lfsr_ranged_random_top_test.sv
